FILE: rtl/core/rhp_pkg.sv
// Shared types and constants for the RGB to HSV pixel converter.
// No dependencies; imported by every module of the block.
package rhp_pkg;

  localparam int CH_W       = 8;   // one color channel
  localparam int HUE_W      = 8;   // hue in half degrees
  localparam int SAT_W      = 8;
  localparam int BRIGHT_W   = 7;

  localparam int HUE_NUM_W  = 17;  // 60*diff + 360*d stays below 2^17
  localparam int SAT_NUM_W  = 16;  // d*255 stays below 2^16
  localparam int QUO_W      = 9;   // hue in degrees reaches 420 before the fold

  localparam int RHP_QBITS_PER_STAGE = 3;

  localparam int HUE_SCALE  = 60;
  localparam int OFF_RED    = 360;
  localparam int OFF_GREEN  = 120;
  localparam int OFF_BLUE   = 240;
  localparam int DEG_FULL   = 360;
  localparam int SAT_SCALE  = 255;
  localparam int VAL_SCALE  = 100;
  localparam int HUE_MAX    = 179;
  localparam int BRIGHT_MAX = 100;
  localparam int CH_FULL    = 255;

  // Front end has two register stages, the output one more.
  localparam int PREP_LAT   = 2;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } hue_sec_e;

  // Side data that rides along with the hue divider.
  typedef struct packed {
    logic                gray;
    logic [BRIGHT_W-1:0] bright;
  } pix_side_t;

  // Front-end result handed to both dividers.
  typedef struct packed {
    logic                 valid;
    logic                 black;
    logic [HUE_NUM_W-1:0] hue_num;
    logic [CH_W-1:0]      delta;
    logic [SAT_NUM_W-1:0] sat_num;
    logic [CH_W-1:0]      max_ch;
    pix_side_t            side;
  } prep_t;

endpackage

FILE: rtl/core/rhp_prep.sv
// Front end of the converter: max/min, sector, then dividends and brightness.
// Depends on rhp_pkg.
module rhp_prep
  import rhp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [CH_W-1:0] red_i,
  input  logic [CH_W-1:0] green_i,
  input  logic [CH_W-1:0] blue_i,
  output prep_t           prep_o
);

  // Stage 1 registers
  logic                   vld1_q;
  logic [CH_W-1:0]        mx1_q, mx1_d;
  logic [CH_W-1:0]        dl1_q, dl1_d;
  logic signed [CH_W:0]   df1_q, df1_d;
  hue_sec_e               sec1_q, sec1_d;

  // Stage 2 registers
  logic                   vld2_q;
  logic [HUE_NUM_W-1:0]   num2_q, num2_d;
  logic [SAT_NUM_W-1:0]   snum2_q, snum2_d;
  logic [CH_W-1:0]        mx2_q;
  logic [CH_W-1:0]        dl2_q;
  logic [BRIGHT_W-1:0]    br2_q, br2_d;

  logic [CH_W-1:0]        mn1;
  logic signed [CH_W:0]   r_s, g_s, b_s;

  always_comb begin
    r_s = $signed({1'b0, red_i});
    g_s = $signed({1'b0, green_i});
    b_s = $signed({1'b0, blue_i});
    mx1_d = red_i;
    if (green_i > mx1_d) mx1_d = green_i;
    if (blue_i > mx1_d) mx1_d = blue_i;
    mn1 = red_i;
    if (green_i < mn1) mn1 = green_i;
    if (blue_i < mn1) mn1 = blue_i;
    dl1_d = mx1_d - mn1;
    // red wins ties, then green
    if (mx1_d == red_i) begin
      sec1_d = SEC_RED;
      df1_d  = g_s - b_s;
    end else if (mx1_d == green_i) begin
      sec1_d = SEC_GREEN;
      df1_d  = b_s - r_s;
    end else begin
      sec1_d = SEC_BLUE;
      df1_d  = r_s - g_s;
    end
  end

  logic        [8:0]  off;
  logic signed [17:0] prod_s;
  logic        [17:0] off_prod;
  logic signed [17:0] num_s;
  logic        [14:0] val_prod;
  logic        [15:0] val_sum;

  always_comb begin
    case (sec1_q)
      SEC_RED:   off = 9'(OFF_RED);
      SEC_GREEN: off = 9'(OFF_GREEN);
      SEC_BLUE:  off = 9'(OFF_BLUE);
      default:   off = '0;
    endcase
    prod_s   = 18'(df1_q) * 18'(HUE_SCALE);
    off_prod = 18'(dl1_q) * 18'(off);
    num_s    = prod_s + $signed(off_prod);
    num2_d   = num_s[HUE_NUM_W-1:0];
    // d*255 as a shift and subtract
    snum2_d  = (SAT_NUM_W'(dl1_q) << CH_W) - SAT_NUM_W'(dl1_q);
    // floor(y/255) for y below 65535: (y + (y>>8) + 1) >> 8
    val_prod = 15'(mx1_q) * 15'(VAL_SCALE);
    val_sum  = 16'(val_prod) + 16'(val_prod >> 8) + 16'd1;
    br2_d    = val_sum[8 +: BRIGHT_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mx1_q   <= mx1_d;
    dl1_q   <= dl1_d;
    df1_q   <= df1_d;
    sec1_q  <= sec1_d;
    num2_q  <= num2_d;
    snum2_q <= snum2_d;
    mx2_q   <= mx1_q;
    dl2_q   <= dl1_q;
    br2_q   <= br2_d;
  end

  always_comb begin
    prep_o.valid       = vld2_q;
    prep_o.black       = (mx2_q == '0);
    prep_o.hue_num     = num2_q;
    prep_o.delta       = dl2_q;
    prep_o.sat_num     = snum2_q;
    prep_o.max_ch      = mx2_q;
    prep_o.side.gray   = (dl2_q == '0);
    prep_o.side.bright = br2_q;
  end

endmodule

FILE: rtl/core/rhp_div.sv
// Pipelined restoring divider, a few quotient bits per register stage.
// Depends on rhp_pkg for default widths.
module rhp_div
  import rhp_pkg::*;
#(
  parameter int NUM_W  = HUE_NUM_W,
  parameter int DEN_W  = CH_W,
  parameter int QW     = QUO_W,
  parameter int STEP   = RHP_QBITS_PER_STAGE,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QW-1:0]     quo_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int NS = (QW + STEP - 1) / STEP;
  localparam int WW = NUM_W + QW;

  logic              vld_q  [NS];
  logic [NUM_W-1:0]  rem_q  [NS];
  logic [QW-1:0]     quo_q  [NS];
  logic [DEN_W-1:0]  den_q  [NS];
  logic [SIDE_W-1:0] side_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic              vld_in;
    logic [NUM_W-1:0]  rem_in;
    logic [QW-1:0]     quo_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [NUM_W-1:0]  rem_d;
    logic [QW-1:0]     quo_d;

    if (s == 0) begin : g_head
      assign vld_in  = valid_i;
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_body
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      logic [WW-1:0] sh;
      logic          fit;
      sh    = '0;
      fit   = 1'b0;
      rem_d = rem_in;
      quo_d = quo_in;
      for (int k = 0; k < STEP; k++) begin
        if (s * STEP + k < QW) begin
          // try subtracting den at the next quotient bit, MSB first
          sh    = WW'(den_in) << (QW - 1 - s * STEP - k);
          fit   = (WW'(rem_d) >= sh);
          if (fit) rem_d = rem_d - sh[NUM_W-1:0];
          quo_d = (quo_d << 1) | QW'(fit);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d;
      quo_q[s]  <= quo_d;
      den_q[s]  <= den_in;
      side_q[s] <= side_in;
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quo_o   = quo_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

FILE: rtl/core/rgb_to_hsv_pixel.sv
// RGB to HSV pixel converter, top level.
// Throughput: one pixel per clock; busy_o is always low and the receiver cannot stall.
// The depth is set by the two restoring dividers, which resolve QBITS_PER_STAGE bits
// each per register stage. Reset clears only the valid bits; no beat is in flight after.
// Depends on rhp_pkg, rhp_prep and rhp_div.
module rgb_to_hsv_pixel
  import rhp_pkg::*;
#(
  parameter int QBITS_PER_STAGE = RHP_QBITS_PER_STAGE
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [CH_W-1:0]     red_i,
  input  logic [CH_W-1:0]     green_i,
  input  logic [CH_W-1:0]     blue_i,
  output logic                done_o,
  output logic [HUE_W-1:0]    hue_o,
  output logic [SAT_W-1:0]    saturation_o,
  output logic [BRIGHT_W-1:0] brightness_o
);

  // The pipeline never holds a beat back, so a new pixel is always welcome.
  assign busy_o = 1'b0;

  prep_t prep;

  // Two stages: max/min and sector, then the hue and saturation dividends and brightness.
  rhp_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .prep_o  (prep)
  );

  logic            hue_vld;
  logic [QUO_W-1:0] hue_deg;
  pix_side_t       hue_side;

  // Hue in whole degrees: (60*diff + offset*d) / d, in 60..420 when d is nonzero.
  rhp_div #(
    .NUM_W  (HUE_NUM_W),
    .DEN_W  (CH_W),
    .QW     (QUO_W),
    .STEP   (QBITS_PER_STAGE),
    .SIDE_W ($bits(pix_side_t))
  ) u_hue_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep.valid),
    .num_i   (prep.hue_num),
    .den_i   (prep.delta),
    .side_i  (prep.side),
    .valid_o (hue_vld),
    .quo_o   (hue_deg),
    .side_o  (hue_side)
  );

  logic             sat_vld;
  logic [QUO_W-1:0] sat_quo;
  logic             sat_black;

  // Saturation: d*255 / max. Same quotient width keeps both dividers in step.
  rhp_div #(
    .NUM_W  (SAT_NUM_W),
    .DEN_W  (CH_W),
    .QW     (QUO_W),
    .STEP   (QBITS_PER_STAGE),
    .SIDE_W (1)
  ) u_sat_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep.valid),
    .num_i   (prep.sat_num),
    .den_i   (prep.max_ch),
    .side_i  (prep.black),
    .valid_o (sat_vld),
    .quo_o   (sat_quo),
    .side_o  (sat_black)
  );

  logic                done_q, done_d;
  logic [HUE_W-1:0]    hue_q, hue_d;
  logic [SAT_W-1:0]    sat_q, sat_d;
  logic [BRIGHT_W-1:0] bright_q;
  logic [QUO_W-1:0]    deg_fold;

  always_comb begin
    done_d = hue_vld & sat_vld;
    // Fold 360..420 back into 0..60, then halve to half degrees.
    if (hue_deg >= QUO_W'(DEG_FULL)) begin
      deg_fold = hue_deg - QUO_W'(DEG_FULL);
    end else begin
      deg_fold = hue_deg;
    end
    // Gray pixels divide by zero; drop the quotient and force hue to zero.
    hue_d = hue_side.gray ? '0 : deg_fold[HUE_W:1];
    // Black pixels likewise force saturation to zero.
    sat_d = sat_black ? '0 : sat_quo[SAT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q    <= hue_d;
    sat_q    <= sat_d;
    bright_q <= hue_side.bright;
  end

  assign done_o       = done_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;

endmodule

FILE: rtl/core/rhp_chk.sv
// Port-level checker for the RGB to HSV converter, bound to the top level.
// Depends on rhp_pkg; the bind hands down the quotient bits per stage.
module rhp_chk
  import rhp_pkg::*;
#(
  parameter int QBITS = RHP_QBITS_PER_STAGE,
  parameter int LAT   = PREP_LAT + (QUO_W + QBITS - 1) / QBITS + 1
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input logic [CH_W-1:0]     red_i,
  input logic [CH_W-1:0]     green_i,
  input logic [CH_W-1:0]     blue_i,
  input logic                done_o,
  input logic [HUE_W-1:0]    hue_o,
  input logic [SAT_W-1:0]    saturation_o,
  input logic [BRIGHT_W-1:0] brightness_o
);

  // Every accepted beat gives a result strobe once through the front-end, divider and output registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("accepted beat gives no result strobe");

  // Nothing else raises the result strobe.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result strobe without an accepted beat");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hue_o <= HUE_W'(HUE_MAX)))
    else $error("hue out of range");

  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(red_i == green_i && green_i == blue_i, LAT)
      |-> (hue_o == '0 && saturation_o == '0))
    else $error("gray pixel gives nonzero hue or saturation");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(red_i == CH_W'(CH_FULL) || green_i == CH_W'(CH_FULL) ||
                    blue_i == CH_W'(CH_FULL), LAT)
      |-> (brightness_o == BRIGHT_W'(BRIGHT_MAX)))
    else $error("full-scale pixel does not give full brightness");

endmodule

bind rgb_to_hsv_pixel rhp_chk #(
  .QBITS (QBITS_PER_STAGE)
) u_rhp_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .red_i        (red_i),
  .green_i      (green_i),
  .blue_i       (blue_i),
  .done_o       (done_o),
  .hue_o        (hue_o),
  .saturation_o (saturation_o),
  .brightness_o (brightness_o)
);
